>>> rtl/ced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_pkg: shared types and helpers for the C escape decoder
// Parse phase codes, the result group that travels from the decoder to the
// output buffer, and byte classification functions.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MaxResults = 3;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerX    = 8'h78;

  typedef enum logic [5:0] {
    PH_PLAIN = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_OCT1  = 6'b000100,
    PH_OCT2  = 6'b001000,
    PH_HEX0  = 6'b010000,
    PH_HEX1  = 6'b100000
  } ced_phase_t;

  // Up to three result bytes produced by one input transaction.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       last;
  } ced_group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } ced_hex_t;

  function automatic logic is_oct(input logic [7:0] b);
    return b inside {[8'h30:8'h37]};
  endfunction

  function automatic ced_hex_t hex_val(input logic [7:0] b);
    ced_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.val = 4'(b - 8'h61 + 8'd10);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.val = 4'(b - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h61:   r = 8'd7;   // a
      8'h62:   r = 8'd8;   // b
      8'h66:   r = 8'd12;  // f
      8'h6E:   r = 8'd10;  // n
      8'h72:   r = 8'd13;  // r
      8'h74:   r = 8'd9;   // t
      8'h76:   r = 8'd11;  // v
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ced_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_in_if: escaped text input channel
// valid/ready handshake carrying one text byte and an end-of-string flag.
// ----------------------------------------------------------------------------
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

>>> rtl/ced_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_out_if: unescaped text output channel
// valid/ready handshake carrying one result byte and an end-of-string flag.
// ----------------------------------------------------------------------------
interface ced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;

  modport source (output valid, output out_byte, output out_end, input ready);
  modport sink   (input valid, input out_byte, input out_end, output ready);
endinterface

>>> rtl/ced_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_decode: escape parser
// Holds the parse phase and the pending digit value, and turns one input
// byte into a group of zero to three result bytes.
// ----------------------------------------------------------------------------
module ced_decode
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output ced_group_t grp
);

  ced_phase_t phase, phase_next;
  logic [7:0] pend, pend_next;

  always_comb begin
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            n;
    logic                       do_plain;
    logic [7:0]                 v;
    ced_hex_t                   hv;

    bytes      = '0;
    n          = '0;
    do_plain   = 1'b0;
    phase_next = PH_PLAIN;
    pend_next  = pend;
    hv         = hex_val(in_byte);
    v          = {pend[4:0], 3'b000} + {5'd0, in_byte[2:0]};

    case (phase)
      PH_ESC: begin
        if (is_oct(in_byte)) begin
          pend_next = {5'd0, in_byte[2:0]};
          if (in_end) begin
            bytes[n] = {5'd0, in_byte[2:0]};
            n = n + 1'b1;
          end else begin
            phase_next = PH_OCT1;
          end
        end else if (in_byte == ChLowerX) begin
          if (in_end) begin
            bytes[n] = ChBackslash;
            n = n + 1'b1;
            bytes[n] = ChLowerX;
            n = n + 1'b1;
          end else begin
            phase_next = PH_HEX0;
          end
        end else begin
          bytes[n] = map_escape(in_byte);
          n = n + 1'b1;
        end
      end
      PH_OCT1: begin
        if (is_oct(in_byte)) begin
          // third digit allowed only while the value still fits in 8 bits
          if (v <= 8'd31 && !in_end) begin
            pend_next  = v;
            phase_next = PH_OCT2;
          end else begin
            bytes[n] = v;
            n = n + 1'b1;
          end
        end else begin
          bytes[n] = pend;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      PH_OCT2: begin
        if (is_oct(in_byte)) begin
          bytes[n] = v;
          n = n + 1'b1;
        end else begin
          bytes[n] = pend;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      PH_HEX0: begin
        if (hv.ok) begin
          pend_next = {4'd0, hv.val};
          if (in_end) begin
            bytes[n] = {4'd0, hv.val};
            n = n + 1'b1;
          end else begin
            phase_next = PH_HEX1;
          end
        end else begin
          bytes[n] = ChBackslash;
          n = n + 1'b1;
          bytes[n] = ChLowerX;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hv.ok) begin
          bytes[n] = {pend[3:0], hv.val};
          n = n + 1'b1;
        end else begin
          bytes[n] = pend;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // terminating byte is reprocessed as plain text
    if (do_plain) begin
      if (in_byte == ChBackslash && !in_end) begin
        phase_next = PH_ESC;
      end else begin
        bytes[n] = in_byte;
        n = n + 1'b1;
      end
    end

    if (phase_next == PH_PLAIN) pend_next = '0;
    if (in_end) begin
      phase_next = PH_PLAIN;
      pend_next  = '0;
    end

    grp.bytes = bytes;
    grp.cnt   = n;
    grp.last  = in_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
      pend  <= '0;
    end else if (take) begin
      phase <= phase_next;
      pend  <= pend_next;
    end
  end

endmodule

>>> rtl/ced_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_emit: result buffer
// Registers one result group and hands its bytes out one per transaction.
// ----------------------------------------------------------------------------
module ced_emit
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  ced_group_t grp,
  output logic       room,
  output logic       valid,
  input  logic       ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic [MaxResults-1:0][7:0] bytes;
  logic [CntW-1:0]            cnt;
  logic                       last;

  assign valid    = (cnt != '0);
  assign out_byte = bytes[0];
  assign out_end  = last && (cnt == CntW'(1));
  // free now, or the final byte leaves this cycle
  assign room     = (cnt == '0) || ((cnt == CntW'(1)) && ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (valid && ready) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= grp.bytes;
      last  <= grp.last;
    end else if (valid && ready) begin
      bytes <= {8'd0, bytes[MaxResults-1:1]};
    end
  end

endmodule

>>> rtl/c_escape_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_decoder_top: streaming C string unescaper
// Parser plus result buffer between an escaped-text and a plain-text channel.
// ----------------------------------------------------------------------------
// Accepts one escaped text byte per cycle while the result buffer has room,
// and presents its unescaped bytes on the output channel from the cycle after
// acceptance. An input transaction that yields zero or one byte does not hold
// the input, so ordinary text streams at one byte per clock while the receiver
// is ready; one that yields more (up to three, e.g. a dangling \x followed by
// a plain byte) holds the input until the single output port, draining the
// three-byte result buffer, passes its final byte. out_end marks the last byte
// produced for an input byte that carried in_end; any escape still open at end of string is flushed then.
module c_escape_decoder_top
  import ced_pkg::*;
(
  input logic clk,
  input logic rst,
  ced_in_if.sink    din,
  ced_out_if.source dout
);

  ced_group_t grp;
  logic       room;
  logic       take;

  // no transaction is taken while in reset
  assign din.ready = room && !rst;
  assign take      = din.valid && room && !rst;

  ced_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (din.in_byte),
    .in_end  (din.in_end),
    .grp     (grp)
  );

  ced_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .grp      (grp),
    .room     (room),
    .valid    (dout.valid),
    .ready    (dout.ready),
    .out_byte (dout.out_byte),
    .out_end  (dout.out_end)
  );

endmodule

>>> tb/ced_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_checker: scoreboard for the C escape decoder
// Watches both channels. Every accepted input byte is run through a local
// unescape parser that queues the bytes it should produce. Every accepted
// output byte is compared against the head of that queue.
// ----------------------------------------------------------------------------
module ced_checker
  import ced_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ced_in_if    din,
  ced_out_if   dout,
  output int   errors,
  output int   outstanding,
  output int   bytes_in,
  output int   bytes_out,
  output int   strings_done
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  text_byte_t want_q[$];
  ced_phase_t phase;
  logic [7:0] held;

  task automatic put_byte(input logic [7:0] b);
    text_byte_t item;
    item.data = b;
    item.last = 1'b0;
    want_q.insert(want_q.size(), item);
  endtask

  // Advance the parser by one escaped byte and queue what it yields.
  task automatic unescape_byte(input logic [7:0] b, input logic e);
    int         base;
    ced_phase_t nxt;
    logic       replay;
    logic       oct_ok;
    logic       hex_ok;
    logic [3:0] digit;
    logic [7:0] v;
    base   = want_q.size();
    nxt    = PH_PLAIN;
    replay = 1'b0;
    oct_ok = (b >= "0") && (b <= "7");
    hex_ok = 1'b1;
    digit  = 4'd0;
    if ((b >= "0") && (b <= "9")) begin
      digit = 4'(b - "0");
    end else if ((b >= "a") && (b <= "f")) begin
      digit = 4'(b - "a" + 8'd10);
    end else if ((b >= "A") && (b <= "F")) begin
      digit = 4'(b - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end

    case (phase)
      PH_ESC: begin
        if (oct_ok) begin
          held = b - "0";
          if (e) put_byte(held);
          else nxt = PH_OCT1;
        end else if (b == ChLowerX) begin
          if (e) begin
            put_byte(ChBackslash);
            put_byte(ChLowerX);
          end else begin
            nxt = PH_HEX0;
          end
        end else begin
          case (b)
            "a":     put_byte(8'd7);
            "b":     put_byte(8'd8);
            "f":     put_byte(8'd12);
            "n":     put_byte(8'd10);
            "r":     put_byte(8'd13);
            "t":     put_byte(8'd9);
            "v":     put_byte(8'd11);
            default: put_byte(b);
          endcase
        end
      end
      PH_OCT1: begin
        if (oct_ok) begin
          v = (held << 3) + (b - "0");
          // third digit allowed only while the value still fits in 8 bits
          if ((v <= 8'd31) && !e) begin
            held = v;
            nxt  = PH_OCT2;
          end else begin
            put_byte(v);
          end
        end else begin
          put_byte(held);
          replay = 1'b1;
        end
      end
      PH_OCT2: begin
        if (oct_ok) begin
          put_byte((held << 3) + (b - "0"));
        end else begin
          put_byte(held);
          replay = 1'b1;
        end
      end
      PH_HEX0: begin
        if (hex_ok) begin
          held = {4'd0, digit};
          if (e) put_byte(held);
          else nxt = PH_HEX1;
        end else begin
          put_byte(ChBackslash);
          put_byte(ChLowerX);
          replay = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hex_ok) begin
          put_byte((held << 4) + {4'd0, digit});
        end else begin
          put_byte(held);
          replay = 1'b1;
        end
      end
      default: replay = 1'b1;
    endcase

    // byte that closed an escape (or plain text) goes through as text
    if (replay) begin
      if ((b == ChBackslash) && !e) nxt = PH_ESC;
      else put_byte(b);
    end

    if ((nxt == PH_PLAIN) || e) held = 8'd0;
    phase = e ? PH_PLAIN : nxt;

    if (e && (want_q.size() > base)) begin
      want_q[want_q.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin : monitor
    text_byte_t want;
    if (rst) begin
      phase        = PH_PLAIN;
      held         = 8'd0;
      want_q.delete();
      errors       = 0;
      outstanding  = 0;
      bytes_in     = 0;
      bytes_out    = 0;
      strings_done = 0;
    end else begin
      if (dout.valid && dout.ready) begin
        bytes_out++;
        if (want_q.size() == 0) begin
          errors++;
          $error("unexpected output transaction: out_byte %02h out_end %0b",
                 dout.out_byte, dout.out_end);
        end else begin
          want = want_q.pop_front();
          if (dout.out_byte !== want.data) begin
            errors++;
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.data, dout.out_byte);
          end
          if (dout.out_end !== want.last) begin
            errors++;
            $error("out_end mismatch: expected %0b, actual %0b",
                   want.last, dout.out_end);
          end
        end
      end
      if (din.valid && din.ready) begin
        bytes_in++;
        if (din.in_end) strings_done++;
        unescape_byte(din.in_byte, din.in_end);
      end
      outstanding = want_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the C escape decoder
// Drives escaped text (a directed set of escapes, then random well-formed
// and broken escape sequences with random string ends) under three idle
// profiles, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ced_pkg::*;

  logic clk;
  logic rst;
  int   src_idle;
  int   snk_idle;
  int   sent;
  int   errors;
  int   outstanding;
  int   bytes_in;
  int   bytes_out;
  int   strings_done;

  ced_in_if  in_ch ();
  ced_out_if out_ch ();

  c_escape_decoder_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  ced_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .din          (in_ch),
    .dout         (out_ch),
    .errors       (errors),
    .outstanding  (outstanding),
    .bytes_in     (bytes_in),
    .bytes_out    (bytes_out),
    .strings_done (strings_done)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= snk_idle);
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.in_end  = e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input logic e_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], e_last && (i == s.len() - 1));
  endtask

  // Random text byte; roughly one in twelve closes the string
  task automatic send_text(input logic [7:0] b);
    send_byte(b, $urandom_range(11) == 0);
  endtask

  function automatic logic [7:0] hex_char(input int k);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 16) return "a" + 8'(k - 10);
    return "A" + 8'(k - 16);
  endfunction

  task automatic random_token();
    string letters;
    int    ndig;
    letters = "abfnrtv\\\"'";
    case ($urandom_range(9))
      0, 1: send_text(8'($urandom_range(32, 126)));
      2:    send_text(8'($urandom_range(255)));
      3, 4: begin
        send_text(ChBackslash);
        if ($urandom_range(3) == 0) send_text(8'($urandom_range(255)));
        else send_text(letters[$urandom_range(letters.len() - 1)]);
      end
      5, 6: begin
        send_text(ChBackslash);
        ndig = $urandom_range(1, 3);
        for (int i = 0; i < ndig; i++) send_text("0" + 8'($urandom_range(7)));
      end
      7, 8: begin
        send_text(ChBackslash);
        send_text(ChLowerX);
        ndig = $urandom_range(0, 2);
        for (int i = 0; i < ndig; i++) send_text(hex_char($urandom_range(21)));
      end
      default: send_byte(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_end  = 1'b0;
    src_idle      = 28;
    snk_idle      = 74;
    sent          = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: escape letters, 3-digit octal, octal cut at two digits,
    // hex with two/none digits, pending escapes at end, trailing backslash
    send_str("\\n", 1'b0);
    send_str("\\101", 1'b0);
    send_str("\\477", 1'b0);
    send_str("\\x4F", 1'b0);
    send_str("\\xg", 1'b0);
    send_str("\\x", 1'b1);
    send_str("\\7", 1'b1);
    send_str("\\", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    while (sent < 104) random_token();
    src_idle = 74;
    snk_idle = 28;
    while (sent < 184) random_token();
    src_idle = 0;
    snk_idle = 0;
    while (sent < 264) random_token();
    send_byte(8'h2E, 1'b1);
    in_ch.valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (outstanding != 0) $error("%0d expected bytes never arrived", outstanding);
    $display("Streamed %0d escaped bytes over %0d strings; %0d unescaped bytes checked",
             bytes_in, strings_done, bytes_out);
    $display("Idle mix: sender 28%%/receiver 74%%, then reversed, then back-to-back");
    if ((errors == 0) && (outstanding == 0)) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
